// ===== design/tmbc_pkg.sv =====
`default_nettype none
package tmbc_pkg;

   // fixed field widths
   localparam int POS_W      = 16;
   localparam int DT_W       = 16;
   localparam int CELL_IN_W  = 6;
   localparam int CALC_W     = 20;
   localparam int PROD_W     = 33;
   localparam int RND_W      = 34;
   localparam int HALF_W     = 9;
   localparam int DISP_SHIFT = 16;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int MAP_DIM_W  = 7;
   localparam int BOX_SIZE_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_SIZE   = 2'd2;

   localparam logic [MAP_DIM_W-1:0]  MAP_DIM_RESET  = 7'd64;
   localparam logic [BOX_SIZE_W-1:0] BOX_SIZE_RESET = 9'd256;

   // item operations
   localparam logic [1:0] OP_WRITE_CELL = 2'd0;
   localparam logic [1:0] OP_LOAD       = 2'd1;
   localparam logic [1:0] OP_STEP       = 2'd2;

   // shared unit operations
   localparam logic [1:0] ALU_MUL    = 2'd0;
   localparam logic [1:0] ALU_MOVE   = 2'd1;
   localparam logic [1:0] ALU_CHOOSE = 2'd2;
   localparam logic [1:0] ALU_PUSH   = 2'd3;

   typedef struct packed {
      logic [1:0]                op;
      logic signed [POS_W-1:0]   pos_a;
      logic signed [POS_W-1:0]   pos_b;
      logic signed [POS_W-1:0]   c_a;
      logic signed [POS_W-1:0]   c_b;
      logic signed [POS_W-1:0]   vel;
      logic                      plus_a;
      logic                      plus_b;
      logic [HALF_W-1:0]         half;
      logic [DT_W-1:0]           dt;
      logic signed [PROD_W-1:0]  prod;
   } alu_cmd_type;

   typedef struct packed {
      logic signed [POS_W-1:0]   pos;
      logic signed [POS_W-1:0]   vel;
      logic signed [PROD_W-1:0]  prod;
      logic                      axis_x;
   } alu_res_type;

endpackage
`default_nettype wire

// ===== design/tmbc_req_if.sv =====
`default_nettype none
interface tmbc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic [5:0]         cell_col;
   logic [5:0]         cell_row;
   logic               cell_solid;
   logic signed [15:0] load_pos_x;
   logic signed [15:0] load_pos_y;
   logic signed [15:0] load_vel_x;
   logic signed [15:0] load_vel_y;
   logic [15:0]        delta_time;

   modport source (
      output valid, operation, cell_col, cell_row, cell_solid,
             load_pos_x, load_pos_y, load_vel_x, load_vel_y, delta_time,
      input  ready
   );

   modport sink (
      input  valid, operation, cell_col, cell_row, cell_solid,
             load_pos_x, load_pos_y, load_vel_x, load_vel_y, delta_time,
      output ready
   );
endinterface
`default_nettype wire

// ===== design/tmbc_rsp_if.sv =====
`default_nettype none
interface tmbc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] now_pos_x;
   logic signed [15:0] now_pos_y;
   logic signed [15:0] now_vel_x;
   logic signed [15:0] now_vel_y;

   modport source (
      output valid, now_pos_x, now_pos_y, now_vel_x, now_vel_y,
      input  ready
   );

   modport sink (
      input  valid, now_pos_x, now_pos_y, now_vel_x, now_vel_y,
      output ready
   );
endinterface
`default_nettype wire

// ===== design/tmbc_ram.sv =====
`default_nettype none
module tmbc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/tmbc_alu.sv =====
`default_nettype none
module tmbc_alu #(
   parameter int FRAC_BITS = 8
) (
   input  wire tmbc_pkg::alu_cmd_type cmd,
   output tmbc_pkg::alu_res_type      res
);

   localparam logic signed [tmbc_pkg::CALC_W-1:0] UNIT    = tmbc_pkg::CALC_W'(1);
   localparam logic signed [tmbc_pkg::CALC_W-1:0] POS_MAX = tmbc_pkg::CALC_W'(32767);
   localparam logic signed [tmbc_pkg::CALC_W-1:0] POS_MIN = tmbc_pkg::CALC_W'(-32768);
   localparam logic signed [tmbc_pkg::RND_W-1:0]  RND     = tmbc_pkg::RND_W'(32768);

   function automatic logic signed [tmbc_pkg::POS_W-1:0] sat_pos(
      input logic signed [tmbc_pkg::CALC_W-1:0] v
   );
      logic signed [tmbc_pkg::POS_W-1:0] r;
      if (v > POS_MAX) begin
         r = tmbc_pkg::POS_W'(POS_MAX);
      end else if (v < POS_MIN) begin
         r = tmbc_pkg::POS_W'(POS_MIN);
      end else begin
         r = tmbc_pkg::POS_W'(v);
      end
      return r;
   endfunction

   logic signed [tmbc_pkg::CALC_W-1:0] pos_a, pos_b, half_s, ca, cb;
   logic signed [tmbc_pkg::CALC_W-1:0] edge_a_lo, edge_a_hi, edge_b_lo, edge_b_hi;
   logic signed [tmbc_pkg::CALC_W-1:0] edge_a, probe, target, dist_a, dist_b, disp;
   logic signed [tmbc_pkg::RND_W-1:0]  rounded;
   logic                               hit, vel_in;

   always_comb begin
      pos_a  = tmbc_pkg::CALC_W'(cmd.pos_a);
      pos_b  = tmbc_pkg::CALC_W'(cmd.pos_b);
      half_s = $signed(tmbc_pkg::CALC_W'(cmd.half));
      ca     = tmbc_pkg::CALC_W'(cmd.c_a);
      cb     = tmbc_pkg::CALC_W'(cmd.c_b);

      // cell edges: low edge c*ONE, high edge (c+1)*ONE
      edge_a_lo = ca <<< FRAC_BITS;
      edge_a_hi = (ca + UNIT) <<< FRAC_BITS;
      edge_b_lo = cb <<< FRAC_BITS;
      edge_b_hi = (cb + UNIT) <<< FRAC_BITS;

      edge_a = cmd.plus_a ? edge_a_hi : edge_a_lo;
      probe  = cmd.plus_a ? (pos_a + half_s) : (pos_a - half_s);
      target = cmd.plus_a ? (edge_a - half_s) : (edge_a + half_s);
      hit    = cmd.plus_a ? (probe > edge_a) : (probe < edge_a);
      vel_in = cmd.plus_a ? (cmd.vel > 0) : (cmd.vel < 0);

      dist_a = cmd.plus_a ? (edge_a_hi - pos_a) : (pos_a - edge_a_lo);
      dist_b = cmd.plus_b ? (edge_b_hi - pos_b) : (pos_b - edge_b_lo);

      // round to nearest, ties toward plus infinity
      rounded = tmbc_pkg::RND_W'(cmd.prod) + RND;
      disp    = tmbc_pkg::CALC_W'(rounded >>> tmbc_pkg::DISP_SHIFT);

      res        = '0;
      res.pos    = cmd.pos_a;
      res.vel    = cmd.vel;
      unique case (cmd.op)
         tmbc_pkg::ALU_MUL: begin
            res.prod = cmd.vel * $signed({1'b0, cmd.dt});
         end
         tmbc_pkg::ALU_MOVE: begin
            res.pos = sat_pos(pos_a + disp);
         end
         tmbc_pkg::ALU_CHOOSE: begin
            res.axis_x = (dist_a >= dist_b);
         end
         tmbc_pkg::ALU_PUSH: begin
            if (hit) begin
               res.pos = sat_pos(target);
               if (vel_in) begin
                  res.vel = '0;
               end
            end
         end
         default: begin
            res.pos = cmd.pos_a;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== design/tile_map_box_collision_step.sv =====
// Box on a tile map: keeps one square box (position and velocity, Q(16-FRAC_BITS).FRAC_BITS)
// and a MAP_SIDE_MAX x MAP_SIDE_MAX solid map stored one row per RAM word. Every item
// gives one result, the box state after the item. After reset the block sweeps the map
// RAM to empty, one row a cycle, before req ready first rises; configuration writes are
// taken during the sweep. Items are taken one at a time. A load or an unused operation goes
// to the result register with no map or arithmetic work; a cell write whose column and row
// are below MAP_SIDE_MAX first does a read-modify-write of one map row. A step does two
// multiplies and two moves through the shared arithmetic unit, three map row reads, then
// a scan of the eight neighbour cells in which every solid neighbour adds a push through
// the same unit and a corner also an axis choice before its push. The result register
// lets the next item be accepted while a result waits to be taken.
`default_nettype none
module tile_map_box_collision_step #(
   parameter int MAP_SIDE_MAX = 64,
   parameter int FRAC_BITS    = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [tmbc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tmbc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   tmbc_req_if.sink                                req_port,
   tmbc_rsp_if.source                              rsp_port
);

   localparam int IDX_W  = $clog2(MAP_SIDE_MAX);
   localparam int WIDE_W = IDX_W + tmbc_pkg::CELL_IN_W;
   localparam int POS_W  = tmbc_pkg::POS_W;
   localparam int SIZE_W = 18;

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_CLEAR  = 4'd0;
   localparam logic [ST_W-1:0] ST_IDLE   = 4'd1;
   localparam logic [ST_W-1:0] ST_WR_RD  = 4'd2;
   localparam logic [ST_W-1:0] ST_WR_WB  = 4'd3;
   localparam logic [ST_W-1:0] ST_MUL_X  = 4'd4;
   localparam logic [ST_W-1:0] ST_MOV_X  = 4'd5;
   localparam logic [ST_W-1:0] ST_MUL_Y  = 4'd6;
   localparam logic [ST_W-1:0] ST_MOV_Y  = 4'd7;
   localparam logic [ST_W-1:0] ST_RD_M   = 4'd8;
   localparam logic [ST_W-1:0] ST_RD_0   = 4'd9;
   localparam logic [ST_W-1:0] ST_RD_P   = 4'd10;
   localparam logic [ST_W-1:0] ST_RD_END = 4'd11;
   localparam logic [ST_W-1:0] ST_SCAN   = 4'd12;
   localparam logic [ST_W-1:0] ST_CHOOSE = 4'd13;
   localparam logic [ST_W-1:0] ST_PUSH   = 4'd14;
   localparam logic [ST_W-1:0] ST_FIN    = 4'd15;

   localparam logic [IDX_W-1:0]  CLR_LAST = IDX_W'(MAP_SIDE_MAX - 1);
   localparam logic [WIDE_W-1:0] SIDE_WIDE = WIDE_W'(MAP_SIDE_MAX);
   localparam logic [15:0]       SIDE_16   = 16'(MAP_SIDE_MAX);
   localparam logic signed [POS_W-1:0] ONE_CELL = POS_W'(1);

   // control state
   logic [ST_W-1:0]  state_ff, state_in;
   logic [IDX_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [2:0]       k_ff, k_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [tmbc_pkg::MAP_DIM_W-1:0]  map_width_ff, map_width_in;
   logic [tmbc_pkg::MAP_DIM_W-1:0]  map_height_ff, map_height_in;
   logic [tmbc_pkg::BOX_SIZE_W-1:0] box_size_ff, box_size_in;

   // box state
   logic signed [POS_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [POS_W-1:0] vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;

   // working registers
   logic [tmbc_pkg::DT_W-1:0]          dt_ff, dt_in;
   logic signed [tmbc_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [POS_W-1:0]            cx_ff, cx_in, cy_ff, cy_in;
   logic [7:0]                         mask_ff, mask_in;
   logic                               axis_x_ff, axis_x_in;
   logic [IDX_W-1:0]                   wr_col_ff, wr_col_in, wr_row_ff, wr_row_in;
   logic                               wr_solid_ff, wr_solid_in;

   // result payload
   logic signed [POS_W-1:0] rsp_pos_x_ff, rsp_pos_y_ff, rsp_vel_x_ff, rsp_vel_y_ff;
   logic                    load_rsp;

   // map ram
   logic                    ram_wr_en;
   logic [IDX_W-1:0]        ram_wr_addr, ram_rd_addr;
   logic [MAP_SIDE_MAX-1:0] ram_wr_data, ram_rd_data, row_mod;

   tmbc_pkg::alu_cmd_type alu_cmd;
   tmbc_pkg::alu_res_type alu_res;

   logic req_ready, req_fire;
   logic [WIDE_W-1:0] col_wide, row_wide;
   logic              wr_ok;
   logic [SIZE_W-1:0] size_full, one_full, size_lim;
   logic [tmbc_pkg::HALF_W-1:0] half;
   logic [15:0]       w_lim, h_lim;
   logic signed [POS_W-1:0] col_m, col_p, row_m, row_p;
   logic              col_ok_m, col_ok_0, col_ok_p, row_ok_m, row_ok_0, row_ok_p;
   logic              bit_m, bit_0, bit_p;
   logic              corner, push_plus;

   tmbc_ram #(
      .WIDTH (MAP_SIDE_MAX),
      .DEPTH (MAP_SIDE_MAX)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tmbc_alu #(
      .FRAC_BITS (FRAC_BITS)
   ) u_alu (
      .cmd (alu_cmd),
      .res (alu_res)
   );

   assign req_ready      = (state_ff == ST_IDLE);
   assign req_port.ready = req_ready;
   assign req_fire       = req_port.valid && req_ready;

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.now_pos_x = rsp_pos_x_ff;
   assign rsp_port.now_pos_y = rsp_pos_y_ff;
   assign rsp_port.now_vel_x = rsp_vel_x_ff;
   assign rsp_port.now_vel_y = rsp_vel_y_ff;

   // map geometry and box half size
   always_comb begin
      col_wide = WIDE_W'(req_port.cell_col);
      row_wide = WIDE_W'(req_port.cell_row);
      wr_ok    = (col_wide < SIDE_WIDE) && (row_wide < SIDE_WIDE);

      size_full = SIZE_W'(box_size_ff);
      one_full  = SIZE_W'(1) << FRAC_BITS;
      size_lim  = (size_full > one_full) ? one_full : size_full;
      half      = size_lim[tmbc_pkg::HALF_W:1];

      w_lim = (16'(map_width_ff) > SIDE_16) ? SIDE_16 : 16'(map_width_ff);
      h_lim = (16'(map_height_ff) > SIDE_16) ? SIDE_16 : 16'(map_height_ff);

      col_m = cx_ff - ONE_CELL;
      col_p = cx_ff + ONE_CELL;
      row_m = cy_ff - ONE_CELL;
      row_p = cy_ff + ONE_CELL;

      // a cell outside the map in use reads as empty
      col_ok_m = !col_m[POS_W-1] && ($unsigned(col_m) < w_lim);
      col_ok_0 = !cx_ff[POS_W-1] && ($unsigned(cx_ff) < w_lim);
      col_ok_p = !col_p[POS_W-1] && ($unsigned(col_p) < w_lim);
      row_ok_m = !row_m[POS_W-1] && ($unsigned(row_m) < h_lim);
      row_ok_0 = !cy_ff[POS_W-1] && ($unsigned(cy_ff) < h_lim);
      row_ok_p = !row_p[POS_W-1] && ($unsigned(row_p) < h_lim);

      bit_m = col_ok_m && ram_rd_data[col_m[IDX_W-1:0]];
      bit_0 = col_ok_0 && ram_rd_data[cx_ff[IDX_W-1:0]];
      bit_p = col_ok_p && ram_rd_data[col_p[IDX_W-1:0]];

      row_mod            = ram_rd_data;
      row_mod[wr_col_ff] = wr_solid_ff;

      // neighbour order: +x -x +y -y, then +x+y -x+y +x-y -x-y
      corner    = k_ff[2];
      push_plus = corner ? (axis_x_ff ? !k_ff[0] : !k_ff[1]) : !k_ff[0];
   end

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      k_in          = k_ff;
      rsp_valid_in  = rsp_valid_ff;
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      box_size_in   = box_size_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      vel_x_in      = vel_x_ff;
      vel_y_in      = vel_y_ff;
      dt_in         = dt_ff;
      prod_in       = prod_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      mask_in       = mask_ff;
      axis_x_in     = axis_x_ff;
      wr_col_in     = wr_col_ff;
      wr_row_in     = wr_row_ff;
      wr_solid_in   = wr_solid_ff;
      load_rsp      = 1'b0;

      ram_wr_en   = 1'b0;
      ram_wr_addr = clr_cnt_ff;
      ram_wr_data = '0;
      ram_rd_addr = wr_row_ff;

      alu_cmd        = '0;
      alu_cmd.dt     = dt_ff;
      alu_cmd.half   = half;
      alu_cmd.prod   = prod_ff;

      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         unique case (csr_index)
            tmbc_pkg::CSR_MAP_WIDTH:  map_width_in  = csr_wdata[tmbc_pkg::MAP_DIM_W-1:0];
            tmbc_pkg::CSR_MAP_HEIGHT: map_height_in = csr_wdata[tmbc_pkg::MAP_DIM_W-1:0];
            tmbc_pkg::CSR_BOX_SIZE:   box_size_in   = csr_wdata[tmbc_pkg::BOX_SIZE_W-1:0];
            default: begin
               box_size_in = box_size_ff;
            end
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            clr_cnt_in  = clr_cnt_ff + IDX_W'(1);
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_port.operation)
                  tmbc_pkg::OP_WRITE_CELL: begin
                     wr_col_in   = col_wide[IDX_W-1:0];
                     wr_row_in   = row_wide[IDX_W-1:0];
                     wr_solid_in = req_port.cell_solid;
                     state_in    = wr_ok ? ST_WR_RD : ST_FIN;
                  end
                  tmbc_pkg::OP_LOAD: begin
                     pos_x_in = req_port.load_pos_x;
                     pos_y_in = req_port.load_pos_y;
                     vel_x_in = req_port.load_vel_x;
                     vel_y_in = req_port.load_vel_y;
                     state_in = ST_FIN;
                  end
                  tmbc_pkg::OP_STEP: begin
                     dt_in    = req_port.delta_time;
                     state_in = ST_MUL_X;
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_WR_RD: begin
            ram_rd_addr = wr_row_ff;
            state_in    = ST_WR_WB;
         end
         ST_WR_WB: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = wr_row_ff;
            ram_wr_data = row_mod;
            state_in    = ST_FIN;
         end
         ST_MUL_X: begin
            alu_cmd.op  = tmbc_pkg::ALU_MUL;
            alu_cmd.vel = vel_x_ff;
            prod_in     = alu_res.prod;
            state_in    = ST_MOV_X;
         end
         ST_MOV_X: begin
            alu_cmd.op    = tmbc_pkg::ALU_MOVE;
            alu_cmd.pos_a = pos_x_ff;
            pos_x_in      = alu_res.pos;
            state_in      = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            alu_cmd.op  = tmbc_pkg::ALU_MUL;
            alu_cmd.vel = vel_y_ff;
            prod_in     = alu_res.prod;
            state_in    = ST_MOV_Y;
         end
         ST_MOV_Y: begin
            alu_cmd.op    = tmbc_pkg::ALU_MOVE;
            alu_cmd.pos_a = pos_y_ff;
            pos_y_in      = alu_res.pos;
            // box cell is fixed from here on for all eight checks
            cx_in         = pos_x_ff >>> FRAC_BITS;
            cy_in         = alu_res.pos >>> FRAC_BITS;
            state_in      = ST_RD_M;
         end
         ST_RD_M: begin
            ram_rd_addr = row_m[IDX_W-1:0];
            state_in    = ST_RD_0;
         end
         ST_RD_0: begin
            ram_rd_addr = cy_ff[IDX_W-1:0];
            mask_in     = '0;
            mask_in[3]  = row_ok_m && bit_0;
            mask_in[6]  = row_ok_m && bit_p;
            mask_in[7]  = row_ok_m && bit_m;
            state_in    = ST_RD_P;
         end
         ST_RD_P: begin
            ram_rd_addr = row_p[IDX_W-1:0];
            mask_in[0]  = row_ok_0 && bit_p;
            mask_in[1]  = row_ok_0 && bit_m;
            state_in    = ST_RD_END;
         end
         ST_RD_END: begin
            mask_in[2] = row_ok_p && bit_0;
            mask_in[4] = row_ok_p && bit_p;
            mask_in[5] = row_ok_p && bit_m;
            k_in       = '0;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            if (mask_ff[k_ff]) begin
               if (corner) begin
                  state_in = ST_CHOOSE;
               end else begin
                  axis_x_in = !k_ff[1];
                  state_in  = ST_PUSH;
               end
            end else if (k_ff == 3'd7) begin
               state_in = ST_FIN;
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         ST_CHOOSE: begin
            alu_cmd.op     = tmbc_pkg::ALU_CHOOSE;
            alu_cmd.pos_a  = pos_x_ff;
            alu_cmd.pos_b  = pos_y_ff;
            alu_cmd.c_a    = cx_ff;
            alu_cmd.c_b    = cy_ff;
            alu_cmd.plus_a = !k_ff[0];
            alu_cmd.plus_b = !k_ff[1];
            axis_x_in      = alu_res.axis_x;
            state_in       = ST_PUSH;
         end
         ST_PUSH: begin
            alu_cmd.op     = tmbc_pkg::ALU_PUSH;
            alu_cmd.pos_a  = axis_x_ff ? pos_x_ff : pos_y_ff;
            alu_cmd.vel    = axis_x_ff ? vel_x_ff : vel_y_ff;
            alu_cmd.c_a    = axis_x_ff ? cx_ff : cy_ff;
            alu_cmd.plus_a = push_plus;
            if (axis_x_ff) begin
               pos_x_in = alu_res.pos;
               vel_x_in = alu_res.vel;
            end else begin
               pos_y_in = alu_res.pos;
               vel_y_in = alu_res.vel;
            end
            if (k_ff == 3'd7) begin
               state_in = ST_FIN;
            end else begin
               k_in     = k_ff + 3'd1;
               state_in = ST_SCAN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         k_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
         map_width_ff  <= tmbc_pkg::MAP_DIM_RESET;
         map_height_ff <= tmbc_pkg::MAP_DIM_RESET;
         box_size_ff   <= tmbc_pkg::BOX_SIZE_RESET;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         vel_x_ff      <= '0;
         vel_y_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         k_ff          <= k_in;
         rsp_valid_ff  <= rsp_valid_in;
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
         box_size_ff   <= box_size_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         vel_x_ff      <= vel_x_in;
         vel_y_ff      <= vel_y_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff       <= dt_in;
      prod_ff     <= prod_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      mask_ff     <= mask_in;
      axis_x_ff   <= axis_x_in;
      wr_col_ff   <= wr_col_in;
      wr_row_ff   <= wr_row_in;
      wr_solid_ff <= wr_solid_in;
      if (load_rsp) begin
         rsp_pos_x_ff <= pos_x_ff;
         rsp_pos_y_ff <= pos_y_ff;
         rsp_vel_x_ff <= vel_x_ff;
         rsp_vel_y_ff <= vel_y_ff;
      end
   end

endmodule
`default_nettype wire
